[hdl/ppv_pkg.sv]
`default_nettype none

package ppv_pkg;

  localparam int unsigned LINE_BYTES_DEF  = 136;
  localparam int unsigned LAST_ROW_DEF    = 240;
  localparam int unsigned PAL_ENTRIES     = 32;
  localparam int unsigned PAL_IDX_W       = $clog2(PAL_ENTRIES);

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned ROW_W  = 8;
  localparam int unsigned X_W    = 9;
  localparam int unsigned CHAN_W = 8;

  typedef enum logic {
    OP_VIDEO     = 1'b0,
    OP_PAL_WRITE = 1'b1
  } op_e;

  typedef enum logic {
    CFG_PALETTE_BANK = 1'b0,
    CFG_FLIP_ENABLE  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  localparam logic [CHAN_W-1:0] W3_HI  = 8'h92;
  localparam logic [CHAN_W-1:0] W3_MID = 8'h4a;
  localparam logic [CHAN_W-1:0] W3_LO  = 8'h23;
  localparam logic [CHAN_W-1:0] W2_HI  = 8'had;
  localparam logic [CHAN_W-1:0] W2_LO  = 8'h52;

  // 3-3-2 resistor ladder decode of a raw palette byte
  function automatic rgb_t decode_color(logic [DATA_W-1:0] c);
    rgb_t res;
    res.red   = (c[7] ? W3_HI : 8'h00) + (c[6] ? W3_MID : 8'h00) + (c[5] ? W3_LO : 8'h00);
    res.green = (c[4] ? W3_HI : 8'h00) + (c[3] ? W3_MID : 8'h00) + (c[2] ? W3_LO : 8'h00);
    res.blue  = (c[1] ? W2_HI : 8'h00) + (c[0] ? W2_LO : 8'h00);
    return res;
  endfunction

endpackage

`default_nettype wire

[hdl/packed_pixel_palette_video_out.sv]
`default_nettype none

// Palette video output stage: takes one request per cycle while in_stall_o is
// low, either a palette write (stored in a 32 x 8 palette memory, no result)
// or a video byte that yields one pixel-pair result, registered through stage 1
// and the output registers. The rate is set by the palette memory, which has
// one write port and two registered read ports so both pixels of a pair are
// looked up in the same cycle; row and column come from a reciprocal multiply
// by 1/LINE_BYTES in the first stage and a multiply-back correction in the
// second. The whole pipeline stalls together; in_stall_o is high only while a
// result waits and out_stall_i is high. Palette entries read before they are
// written return undefined colors.
module packed_pixel_palette_video_out #(
  parameter int unsigned LINE_BYTES = ppv_pkg::LINE_BYTES_DEF,
  parameter int unsigned LAST_ROW   = ppv_pkg::LAST_ROW_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,

  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_index_i,
  input  wire logic                        cfg_data_i,

  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic                        operation_i,
  input  wire logic [ppv_pkg::ADDR_W-1:0]  address_i,
  input  wire logic [ppv_pkg::DATA_W-1:0]  data_byte_i,

  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      logic [ppv_pkg::ROW_W-1:0]   row_o,
  output      logic [ppv_pkg::X_W-1:0]     left_x_o,
  output      logic [ppv_pkg::CHAN_W-1:0]  left_red_o,
  output      logic [ppv_pkg::CHAN_W-1:0]  left_green_o,
  output      logic [ppv_pkg::CHAN_W-1:0]  left_blue_o,
  output      logic [ppv_pkg::CHAN_W-1:0]  right_red_o,
  output      logic [ppv_pkg::CHAN_W-1:0]  right_green_o,
  output      logic [ppv_pkg::CHAN_W-1:0]  right_blue_o
);

  import ppv_pkg::*;

  localparam int unsigned RECIP_W = 33;
  localparam int unsigned PROD_W  = ADDR_W + RECIP_W;
  localparam int unsigned REM_W   = 8;
  localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'((64'd1 << 32) / LINE_BYTES);
  localparam logic [ADDR_W-1:0]  LB       = ADDR_W'(LINE_BYTES);
  localparam logic [8:0]         LB9      = 9'(LINE_BYTES);
  localparam logic [ROW_W-1:0]   LAST_LO  = ROW_W'(LAST_ROW);
  localparam logic [X_W-1:0]     X_MIRROR = X_W'(2 * (LINE_BYTES - 1));

  // configuration
  logic bank_q, flip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= 1'b0;
      flip_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PALETTE_BANK: bank_q <= cfg_data_i;
        CFG_FLIP_ENABLE:  flip_q <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  // flow control
  logic advance;
  logic in_acc;

  assign advance    = !out_valid_o || !out_stall_i;
  assign in_stall_o = !advance;
  assign in_acc     = in_valid_i && advance;

  // palette memory
  logic [DATA_W-1:0]    pal_mem [PAL_ENTRIES];
  logic [DATA_W-1:0]    rd_left_q, rd_right_q;
  logic [PAL_IDX_W-1:0] left_idx, right_idx;

  always_comb begin
    if (flip_q) begin
      left_idx  = {bank_q, data_byte_i[7:4]};
      right_idx = {bank_q, data_byte_i[3:0]};
    end else begin
      left_idx  = {bank_q, data_byte_i[3:0]};
      right_idx = {bank_q, data_byte_i[7:4]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && operation_i == OP_PAL_WRITE) begin
      pal_mem[address_i[PAL_IDX_W-1:0]] <= data_byte_i;
    end
    if (advance) begin
      rd_left_q  <= pal_mem[left_idx];
      rd_right_q <= pal_mem[right_idx];
    end
  end

  // stage 1: reciprocal estimate of the quotient
  logic              s1_valid_q;
  logic [ADDR_W-1:0] s1_addr_q;
  logic [PROD_W-1:0] s1_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_acc && operation_i == OP_VIDEO;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_addr_q <= address_i;
      s1_prod_q <= PROD_W'(address_i) * PROD_W'(RECIP);
    end
  end

  // stage 2: multiply back and fix the estimate, which is low by at most one
  logic [ADDR_W-1:0] q_est, back, diff;
  logic              fix;
  logic [REM_W-1:0]  rem;
  logic [ROW_W-1:0]  y_lo;
  logic [X_W-1:0]    x_pos;
  logic [ROW_W-1:0]  row_d;
  logic [X_W-1:0]    left_x_d;
  rgb_t              left_rgb, right_rgb;

  always_comb begin
    q_est    = s1_prod_q[32 +: ADDR_W];
    back     = ADDR_W'(q_est * LB9);
    diff     = s1_addr_q - back;
    fix      = diff >= LB;
    rem      = fix ? REM_W'(diff - LB) : REM_W'(diff);
    y_lo     = q_est[ROW_W-1:0] + ROW_W'(fix);
    x_pos    = {rem, 1'b0};
    row_d    = flip_q ? LAST_LO - y_lo : y_lo;
    left_x_d = flip_q ? X_MIRROR - x_pos : x_pos;
    left_rgb  = decode_color(rd_left_q);
    right_rgb = decode_color(rd_right_q);
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      row_o         <= row_d;
      left_x_o      <= left_x_d;
      left_red_o    <= left_rgb.red;
      left_green_o  <= left_rgb.green;
      left_blue_o   <= left_rgb.blue;
      right_red_o   <= right_rgb.red;
      right_green_o <= right_rgb.green;
      right_blue_o  <= right_rgb.blue;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[hdl/ppv_checker.sv]
`default_nettype none

module ppv_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic                        operation_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [ppv_pkg::X_W-1:0]     left_x_o
);

  import ppv_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // input back-pressure only comes from a waiting, stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // pixel pairs always start on an even column
  a_even_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !left_x_o[0])
    else $error("odd left column");

  // a video request with a free pipeline shows up after stage 1 and the output register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && operation_i == OP_VIDEO) ##1 !in_stall_o
      |=> out_valid_o)
    else $error("video result missing");

endmodule

bind packed_pixel_palette_video_out ppv_checker u_ppv_checker (.*);

`default_nettype wire
